// ----- src/usbreq_pkg.sv -----
// ----------------------------------------------------------------------------
// usbreq_pkg
// Shared types and constants for the standard control request decoder:
// request codes, request types, verdict codes and register indexes.
// ----------------------------------------------------------------------------
package usbreq_pkg;

  // defaults for the top level parameters
  localparam int ENDPOINT_COUNT_DEF  = 8;
  localparam int MAX_PACKET_SIZE_DEF = 64;

  // standard request codes (bRequest)
  localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC      = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE = 8'd10;

  // bmRequestType values of standard requests
  localparam logic [7:0] RT_DEV_OUT = 8'h00;
  localparam logic [7:0] RT_IF_OUT  = 8'h01;
  localparam logic [7:0] RT_EP_OUT  = 8'h02;
  localparam logic [7:0] RT_DEV_IN  = 8'h80;
  localparam logic [7:0] RT_IF_IN   = 8'h81;
  localparam logic [7:0] RT_EP_IN   = 8'h82;

  // descriptor types and feature selectors
  localparam logic [7:0] DT_DEVICE          = 8'd1;
  localparam logic [7:0] DT_CONFIG          = 8'd2;
  localparam logic [7:0] FEAT_ENDPOINT_HALT = 8'd0;

  // verdict of one request
  typedef enum logic [2:0] {
    ACT_STALL      = 3'd0,
    ACT_ACK        = 3'd1,
    ACT_INLINE     = 3'd2,
    ACT_SEND_DESC  = 3'd3,
    ACT_CLASS_FWD  = 3'd4,
    ACT_DESC_FWD   = 3'd5,
    ACT_NONE       = 3'd6
  } action_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_DESC_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_DESC_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CONFIGS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EP_ENABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_STATUS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IF_STATUS     = 3'd5;

  // register reset values
  localparam logic [7:0] RST_DEV_DESC_LEN  = 8'd18;
  localparam logic [7:0] RST_CONF_DESC_LEN = 8'd67;
  localparam logic [7:0] RST_NUM_CONFIGS   = 8'd1;
  localparam logic [7:0] RST_EP_ENABLE     = 8'd1;
  localparam logic [7:0] RST_DEV_STATUS    = 8'd0;
  localparam logic [7:0] RST_IF_STATUS     = 8'd0;

endpackage

// ----- src/usbreq_if.sv -----
// ----------------------------------------------------------------------------
// usbreq interfaces
// Valid/ready channels of the request decoder: setup packet in, verdict out,
// and the register write port.
// ----------------------------------------------------------------------------
interface usbreq_setup_if;
  logic        valid;
  logic        ready;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] value_word;
  logic [15:0] index_word;
  logic [15:0] length_word;

  modport source (output valid, request_type, request_code, value_word, index_word,
                  length_word, input ready);
  modport sink (input valid, request_type, request_code, value_word, index_word,
                length_word, output ready);
endinterface

interface usbreq_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] reply_data;
  logic [1:0]  reply_length;
  logic        descriptor_select;
  logic [7:0]  transfer_length;
  logic        needs_zlp;
  logic [6:0]  new_address;
  logic        address_apply;
  logic [7:0]  configuration_out;
  logic        configuration_changed;

  modport source (output valid, action, reply_data, reply_length, descriptor_select,
                  transfer_length, needs_zlp, new_address, address_apply,
                  configuration_out, configuration_changed, input ready);
  modport sink (input valid, action, reply_data, reply_length, descriptor_select,
                transfer_length, needs_zlp, new_address, address_apply,
                configuration_out, configuration_changed, output ready);
endinterface

interface usbreq_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/usb_standard_request_decoder.sv -----
// path: setup word register, then decode into the result register
// throughput: one setup word per cycle while out_if is not stalled; the only stored
// state (halt bits, current configuration) is read and updated in the same decode cycle
// reset: synchronous, active low; clears both word valid flags, the halt bits and the
// current configuration, and loads the register defaults; cfg writes are taken in any cycle
// ----------------------------------------------------------------------------
// usb_standard_request_decoder
// Decodes standard control requests from one setup packet into one verdict,
// keeping per-endpoint halt bits and the current configuration number.
// ----------------------------------------------------------------------------
module usb_standard_request_decoder #(
  parameter int ENDPOINT_COUNT  = usbreq_pkg::ENDPOINT_COUNT_DEF,
  parameter int MAX_PACKET_SIZE = usbreq_pkg::MAX_PACKET_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  usbreq_setup_if.sink    in_if,
  usbreq_result_if.source out_if,
  usbreq_cfg_if.sink      cfg_if
);
  import usbreq_pkg::*;

  localparam int EP_W = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
  localparam logic [7:0] EP_CNT8 = 8'(ENDPOINT_COUNT);
  // number of multiples of the packet size in 0..255
  localparam int MULT_CNT = 255 / MAX_PACKET_SIZE + 1;

  // registers
  logic [7:0] dev_desc_len_r, conf_desc_len_r, num_configs_r;
  logic [7:0] ep_enable_r, dev_status_r, if_status_r;

  logic        in_valid_r;
  logic [7:0]  rtype_r, code_r;
  logic [15:0] wval_r, widx_r, wlen_r;

  logic [ENDPOINT_COUNT-1:0] halt_r, halt_nxt;
  logic [7:0]                cur_cfg_r, cur_cfg_nxt;

  logic        out_valid_r;
  action_t     action_r, action_nxt;
  logic [15:0] rdata_r, rdata_nxt;
  logic [1:0]  rlen_r, rlen_nxt;
  logic        dsel_r, dsel_nxt;
  logic [7:0]  tlen_r, tlen_nxt;
  logic        zlp_r, zlp_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic        apply_r, apply_nxt;
  logic        changed_r, changed_nxt;

  logic       adv;
  logic [6:0] ep;
  logic [7:0] val_lo, dtype, dlen;
  logic       ep_in_range, ep_enabled, halt_bit, dlen_mult;

  // decode advances when the result register is free or being drained
  assign adv          = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || adv;
  assign cfg_if.ready = 1'b1;

  assign ep          = widx_r[6:0];
  assign val_lo      = wval_r[7:0];
  assign dtype       = wval_r[15:8];
  assign ep_in_range = {1'b0, ep} < EP_CNT8;
  assign ep_enabled  = ep_in_range && (ep < 7'd8) && ep_enable_r[ep[2:0]];
  assign halt_bit    = ep_in_range ? halt_r[ep[EP_W-1:0]] : 1'b0;
  assign dlen        = (dtype == DT_DEVICE) ? dev_desc_len_r : conf_desc_len_r;

  // zero-length packet check: descriptor length is a multiple of the packet size
  always_comb begin
    dlen_mult = 1'b0;
    for (int k = 0; k < MULT_CNT; k++) begin
      dlen_mult = dlen_mult | (dlen == 8'(k * MAX_PACKET_SIZE));
    end
  end

  always_comb begin
    action_nxt  = ACT_CLASS_FWD;
    rdata_nxt   = '0;
    rlen_nxt    = '0;
    dsel_nxt    = 1'b0;
    tlen_nxt    = '0;
    zlp_nxt     = 1'b0;
    addr_nxt    = '0;
    apply_nxt   = 1'b0;
    changed_nxt = 1'b0;
    halt_nxt    = halt_r;
    cur_cfg_nxt = cur_cfg_r;
    unique case (code_r)
      REQ_GET_STATUS: begin
        if (rtype_r == RT_DEV_IN) begin
          action_nxt = ACT_INLINE;
          rdata_nxt  = {8'd0, dev_status_r};
          rlen_nxt   = 2'd2;
        end else if (rtype_r == RT_IF_IN) begin
          action_nxt = ACT_INLINE;
          rdata_nxt  = {8'd0, if_status_r};
          rlen_nxt   = 2'd2;
        end else if (rtype_r == RT_EP_IN) begin
          if (ep_in_range) begin
            action_nxt = ACT_INLINE;
            rdata_nxt  = {15'd0, halt_bit};
            rlen_nxt   = 2'd2;
          end else begin
            action_nxt = ACT_STALL;
          end
        end
      end
      REQ_CLEAR_FEATURE: begin
        if (rtype_r == RT_DEV_OUT || rtype_r == RT_IF_OUT) begin
          action_nxt = ACT_STALL;
        end else if (rtype_r == RT_EP_OUT) begin
          if (val_lo == FEAT_ENDPOINT_HALT && ep_enabled) begin
            halt_nxt[ep[EP_W-1:0]] = 1'b0;
            action_nxt = ACT_ACK;
          end else begin
            action_nxt = ACT_STALL;
          end
        end
      end
      REQ_SET_FEATURE: begin
        if (rtype_r == RT_DEV_OUT) begin
          action_nxt = ACT_NONE;
        end else if (rtype_r == RT_IF_OUT) begin
          action_nxt = ACT_STALL;
        end else if (rtype_r == RT_EP_OUT) begin
          // endpoint 0 can not be halted
          if (val_lo == FEAT_ENDPOINT_HALT && ep != 7'd0 && ep_enabled) begin
            halt_nxt[ep[EP_W-1:0]] = 1'b1;
            action_nxt = ACT_ACK;
          end else begin
            action_nxt = ACT_STALL;
          end
        end
      end
      REQ_SET_ADDRESS: begin
        if (rtype_r == RT_DEV_OUT) begin
          action_nxt = ACT_ACK;
          addr_nxt   = wval_r[6:0];
          apply_nxt  = 1'b1;
        end
      end
      REQ_GET_DESC: begin
        if (rtype_r == RT_DEV_IN) begin
          if (dtype == DT_DEVICE || dtype == DT_CONFIG) begin
            action_nxt = ACT_SEND_DESC;
            dsel_nxt   = (dtype == DT_CONFIG);
            if (wlen_r > {8'd0, dlen}) begin
              tlen_nxt = dlen;
              zlp_nxt  = dlen_mult;
            end else begin
              tlen_nxt = wlen_r[7:0];
            end
          end else begin
            action_nxt = ACT_DESC_FWD;
          end
        end
      end
      REQ_GET_CONFIG: begin
        if (rtype_r == RT_DEV_IN) begin
          action_nxt = ACT_INLINE;
          rdata_nxt  = {8'd0, cur_cfg_r};
          rlen_nxt   = 2'd1;
        end
      end
      REQ_SET_CONFIG: begin
        if (rtype_r == RT_DEV_OUT) begin
          if (val_lo <= num_configs_r) begin
            cur_cfg_nxt = val_lo;
            action_nxt  = ACT_ACK;
            changed_nxt = 1'b1;
          end else begin
            action_nxt = ACT_STALL;
          end
        end
      end
      REQ_GET_INTERFACE: begin
        if (rtype_r == RT_IF_IN) begin
          action_nxt = ACT_STALL;
        end
      end
      default: begin
        action_nxt = ACT_CLASS_FWD;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_desc_len_r  <= RST_DEV_DESC_LEN;
      conf_desc_len_r <= RST_CONF_DESC_LEN;
      num_configs_r   <= RST_NUM_CONFIGS;
      ep_enable_r     <= RST_EP_ENABLE;
      dev_status_r    <= RST_DEV_STATUS;
      if_status_r     <= RST_IF_STATUS;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_DEV_DESC_LEN:  dev_desc_len_r  <= cfg_if.data;
        CFG_CONF_DESC_LEN: conf_desc_len_r <= cfg_if.data;
        CFG_NUM_CONFIGS:   num_configs_r   <= cfg_if.data;
        CFG_EP_ENABLE:     ep_enable_r     <= cfg_if.data;
        CFG_DEV_STATUS:    dev_status_r    <= cfg_if.data;
        CFG_IF_STATUS:     if_status_r     <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      rtype_r <= in_if.request_type;
      code_r  <= in_if.request_code;
      wval_r  <= in_if.value_word;
      widx_r  <= in_if.index_word;
      wlen_r  <= in_if.length_word;
    end
  end

  // device state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r      <= '0;
      cur_cfg_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      halt_r      <= halt_nxt;
      cur_cfg_r   <= cur_cfg_nxt;
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      action_r  <= action_nxt;
      rdata_r   <= rdata_nxt;
      rlen_r    <= rlen_nxt;
      dsel_r    <= dsel_nxt;
      tlen_r    <= tlen_nxt;
      zlp_r     <= zlp_nxt;
      addr_r    <= addr_nxt;
      apply_r   <= apply_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_if.valid                 = out_valid_r;
  assign out_if.action                = action_r;
  assign out_if.reply_data            = rdata_r;
  assign out_if.reply_length          = rlen_r;
  assign out_if.descriptor_select     = dsel_r;
  assign out_if.transfer_length       = tlen_r;
  assign out_if.needs_zlp             = zlp_r;
  assign out_if.new_address           = addr_r;
  assign out_if.address_apply         = apply_r;
  assign out_if.configuration_out     = cur_cfg_r;
  assign out_if.configuration_changed = changed_r;

endmodule

// ----- src/usbreq_checker.sv -----
// ----------------------------------------------------------------------------
// usbreq_checker
// Port-level checks of the request decoder, attached by bind.
// ----------------------------------------------------------------------------
module usbreq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_action,
  input logic [1:0] out_reply_length,
  input logic       out_address_apply,
  input logic       out_configuration_changed
);
  import usbreq_pkg::*;

  // a stalled verdict word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action))
    else $error("verdict changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // inline bytes only come with an inline reply
  a_inline_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_INLINE |-> out_reply_length == 2'd0)
    else $error("reply length without inline reply");

  // address and configuration updates are acknowledged
  a_update_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_address_apply || out_configuration_changed) |->
      out_action == ACT_ACK)
    else $error("state update without ack");

endmodule

bind usb_standard_request_decoder usbreq_checker u_usbreq_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .out_valid                 (out_if.valid),
  .out_ready                 (out_if.ready),
  .out_action                (out_if.action),
  .out_reply_length          (out_if.reply_length),
  .out_address_apply         (out_if.address_apply),
  .out_configuration_changed (out_if.configuration_changed)
);
